FILE: design/atapio_pkg.sv
// ----------------------------------------------------------------------------
// atapio_pkg
// Types, codes and helpers shared by the ATA PIO LBA28 read sequencer.
// ----------------------------------------------------------------------------
package atapio_pkg;

   localparam int WORDS_PER_SECTOR = 256;

   localparam logic [1:0] CMD_START  = 2'd0;
   localparam logic [1:0] CMD_STATUS = 2'd1;
   localparam logic [1:0] CMD_DATA   = 2'd2;
   localparam logic [1:0] CMD_RESET  = 2'd3;

   localparam logic [1:0] KIND_WRITE = 2'd0;
   localparam logic [1:0] KIND_POLL  = 2'd1;
   localparam logic [1:0] KIND_DATA  = 2'd2;
   localparam logic [1:0] KIND_ERROR = 2'd3;

   localparam logic [2:0] ERR_NONE       = 3'd0;
   localparam logic [2:0] ERR_RUNNING    = 3'd1;
   localparam logic [2:0] ERR_FAULT      = 3'd2;
   localparam logic [2:0] ERR_BUSY       = 3'd3;
   localparam logic [2:0] ERR_NOT_READY  = 3'd4;
   localparam logic [2:0] ERR_CORRUPT    = 3'd5;
   localparam logic [2:0] ERR_UNEXPECTED = 3'd6;
   localparam logic [2:0] ERR_BAD_COUNT  = 3'd7;

   localparam logic [9:0] PORT_NONE     = 10'h000;
   localparam logic [9:0] PORT_COUNT    = 10'h1F2;
   localparam logic [9:0] PORT_LBA_LOW  = 10'h1F3;
   localparam logic [9:0] PORT_LBA_MID  = 10'h1F4;
   localparam logic [9:0] PORT_LBA_HIGH = 10'h1F5;
   localparam logic [9:0] PORT_DRIVE    = 10'h1F6;
   localparam logic [9:0] PORT_COMMAND  = 10'h1F7;
   localparam logic [9:0] PORT_CONTROL  = 10'h3F6;

   localparam logic [7:0] DRIVE_BASE       = 8'hE0;
   localparam logic [7:0] CMD_READ_SECTORS = 8'h20;
   localparam logic [7:0] CTRL_SRST        = 8'h04;
   localparam logic [7:0] CTRL_CLEAR       = 8'h00;
   localparam logic [7:0] CTRL_NIEN        = 8'h02;

   localparam int ST_ERR  = 0;
   localparam int ST_IDX  = 1;
   localparam int ST_CORR = 2;
   localparam int ST_DRQ  = 3;
   localparam int ST_DF   = 5;
   localparam int ST_RDY  = 6;
   localparam int ST_BSY  = 7;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [27:0] start_lba;
      logic [8:0]  sector_total;
      logic [7:0]  status_byte;
      logic [15:0] read_word;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [9:0]  port;
      logic [7:0]  write_value;
      logic [15:0] data_out;
      logic [15:0] word_address;
      logic [2:0]  error_code;
      logic        request_done;
      logic        last;
   } rsp_type;

   typedef enum logic [2:0] {
      BURST_NONE,
      BURST_ONE,
      BURST_RESET,
      BURST_START,
      BURST_DATA_POLL
   } burst_type;

   typedef struct packed {
      logic        load;
      burst_type   kind;
      rsp_type     first;
      logic [27:0] lba;
      logic [7:0]  count;
      logic        slave;
   } burst_ctl_type;

   function automatic rsp_type make_rsp(logic [1:0] kind, logic [9:0] port,
                                        logic [7:0] value);
      rsp_type r;
      r = '0;
      r.kind = kind;
      r.port = port;
      r.write_value = value;
      return r;
   endfunction

   function automatic rsp_type make_poll();
      return make_rsp(KIND_POLL, PORT_CONTROL, 8'h00);
   endfunction

   function automatic rsp_type make_error(logic [2:0] code);
      rsp_type r;
      r = make_rsp(KIND_ERROR, PORT_NONE, 8'h00);
      r.error_code = code;
      return r;
   endfunction

endpackage

FILE: design/atapio_burst.sv
// ----------------------------------------------------------------------------
// atapio_burst
// Holds one request's result list and hands out one result per ready cycle.
// ----------------------------------------------------------------------------
module atapio_burst (
   input  logic                      clock,
   input  logic                      reset,
   input  atapio_pkg::burst_ctl_type ctl,
   output logic                      free,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output atapio_pkg::rsp_type       rsp_data
);

   logic                  cur_valid_ff;
   atapio_pkg::burst_type cur_kind_ff;
   logic [2:0]            cur_idx_ff;
   atapio_pkg::rsp_type   first_ff;
   logic [27:0]           lba_ff;
   logic [7:0]            count_ff;
   logic                  slave_ff;

   logic [2:0]            last_idx;
   logic                  at_last;
   atapio_pkg::rsp_type   r;

   always_comb begin
      case (cur_kind_ff)
         atapio_pkg::BURST_RESET:     last_idx = 3'd3;
         atapio_pkg::BURST_START:     last_idx = 3'd6;
         atapio_pkg::BURST_DATA_POLL: last_idx = 3'd1;
         default:                     last_idx = 3'd0;
      endcase
   end

   assign at_last = (cur_idx_ff == last_idx);
   assign free    = !cur_valid_ff || (rsp_ready && at_last);

   always_comb begin
      r = first_ff;
      case (cur_kind_ff)
         atapio_pkg::BURST_RESET: begin
            case (cur_idx_ff)
               3'd0: r = atapio_pkg::make_rsp(atapio_pkg::KIND_WRITE,
                                             atapio_pkg::PORT_CONTROL,
                                             atapio_pkg::CTRL_SRST);
               3'd1: r = atapio_pkg::make_rsp(atapio_pkg::KIND_WRITE,
                                             atapio_pkg::PORT_CONTROL,
                                             atapio_pkg::CTRL_CLEAR);
               3'd2: r = atapio_pkg::make_rsp(atapio_pkg::KIND_WRITE,
                                             atapio_pkg::PORT_CONTROL,
                                             atapio_pkg::CTRL_NIEN);
               default: r = atapio_pkg::make_poll();
            endcase
         end
         atapio_pkg::BURST_START: begin
            case (cur_idx_ff)
               3'd0: r = atapio_pkg::make_rsp(atapio_pkg::KIND_WRITE,
                        atapio_pkg::PORT_DRIVE,
                        atapio_pkg::DRIVE_BASE | {3'b000, slave_ff, lba_ff[27:24]});
               3'd1: r = atapio_pkg::make_rsp(atapio_pkg::KIND_WRITE,
                                             atapio_pkg::PORT_COUNT, count_ff);
               3'd2: r = atapio_pkg::make_rsp(atapio_pkg::KIND_WRITE,
                                             atapio_pkg::PORT_LBA_LOW, lba_ff[7:0]);
               3'd3: r = atapio_pkg::make_rsp(atapio_pkg::KIND_WRITE,
                                             atapio_pkg::PORT_LBA_MID, lba_ff[15:8]);
               3'd4: r = atapio_pkg::make_rsp(atapio_pkg::KIND_WRITE,
                                             atapio_pkg::PORT_LBA_HIGH, lba_ff[23:16]);
               3'd5: r = atapio_pkg::make_rsp(atapio_pkg::KIND_WRITE,
                                             atapio_pkg::PORT_COMMAND,
                                             atapio_pkg::CMD_READ_SECTORS);
               default: r = atapio_pkg::make_poll();
            endcase
         end
         atapio_pkg::BURST_DATA_POLL: begin
            if (cur_idx_ff != 3'd0) begin
               r = atapio_pkg::make_poll();
            end
         end
         default: r = first_ff;
      endcase
      r.last = at_last;
   end

   assign rsp_valid = cur_valid_ff;
   assign rsp_data  = r;

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         cur_kind_ff  <= atapio_pkg::BURST_NONE;
         cur_idx_ff   <= 3'd0;
      end else if (ctl.load && free) begin
         cur_valid_ff <= (ctl.kind != atapio_pkg::BURST_NONE);
         cur_kind_ff  <= ctl.kind;
         cur_idx_ff   <= 3'd0;
      end else if (cur_valid_ff && rsp_ready) begin
         if (at_last) begin
            cur_valid_ff <= 1'b0;
         end
         cur_idx_ff <= cur_idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load && free) begin
         first_ff <= ctl.first;
         lba_ff   <= ctl.lba;
         count_ff <= ctl.count;
         slave_ff <= ctl.slave;
      end
   end

endmodule

FILE: design/ata_pio_lba28_read_sequencer_unit.sv
// ----------------------------------------------------------------------------
// ata_pio_lba28_read_sequencer_unit
// Host-side ATA PIO LBA28 read sequencer.
//
// Requests arrive on req_* (valid/ready): start read, status byte, data word
// or reset. Results leave on rsp_* (valid/ready): register writes, status
// polls, data words with their buffer word address, and errors. The last
// flag marks each request's final result. select_slave is written through
// APB address 0; the user writes it only while idle, which is not enforced.
//
// A request is captured in an input register and processed once the result
// stage has room; its first result is offered from the result stage after
// the request has been loaded there. A request produces one result for a
// data word, two for the last word of a sector that is followed by a poll,
// seven for the command write run and four for the reset run; a status
// byte that only moves the phase on produces none.
// When the receiver stalls, one request still waits in the input register,
// then req_ready drops. Reset clears the request state, select_slave and
// both stages; no results are pending after reset.
// ----------------------------------------------------------------------------
module ata_pio_lba28_read_sequencer_unit #(
   parameter int MAX_SECTORS = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  atapio_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output atapio_pkg::rsp_type rsp_data,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [2:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_START_POLL,
      PH_WAIT_DRQ,
      PH_DATA,
      PH_RESET_POLL
   } phase_type;

   logic                select_slave_ff;
   logic                in_valid_ff;
   atapio_pkg::req_type in_ff;

   phase_type   phase_ff, phase_in;
   logic [8:0]  wanted_ff, wanted_in;
   logic [8:0]  done_ff, done_in;
   logic [7:0]  widx_ff, widx_in;
   logic [27:0] lba_ff, lba_in;

   atapio_pkg::burst_ctl_type ctl;
   logic                      free;
   logic                      load;
   logic                      bad;
   logic [8:0]                done_next;
   atapio_pkg::rsp_type       data_rsp;

   assign pready    = 1'b1;
   assign prdata    = (paddr[2] == 1'b0) ? {31'd0, select_slave_ff} : 32'd0;
   assign load      = in_valid_ff && free;
   assign req_ready = !in_valid_ff || load;
   assign bad       = in_ff.status_byte[atapio_pkg::ST_ERR] ||
                      in_ff.status_byte[atapio_pkg::ST_DF];
   assign done_next = done_ff + 9'd1;

   always_comb begin
      data_rsp              = atapio_pkg::make_rsp(atapio_pkg::KIND_DATA,
                                                   atapio_pkg::PORT_NONE, 8'h00);
      data_rsp.data_out     = in_ff.read_word;
      data_rsp.word_address = {done_ff[7:0], widx_ff};
   end

   always_comb begin
      phase_in  = phase_ff;
      wanted_in = wanted_ff;
      done_in   = done_ff;
      widx_in   = widx_ff;
      lba_in    = lba_ff;

      ctl       = '0;
      ctl.load  = load;
      ctl.kind  = atapio_pkg::BURST_NONE;
      ctl.first = atapio_pkg::make_error(atapio_pkg::ERR_UNEXPECTED);
      ctl.lba   = lba_ff;
      ctl.count = wanted_ff[7:0];
      ctl.slave = select_slave_ff;

      case (in_ff.cmd)
         atapio_pkg::CMD_START: begin
            ctl.kind = atapio_pkg::BURST_ONE;
            if (in_ff.sector_total == 9'd0 ||
                in_ff.sector_total > 9'(MAX_SECTORS)) begin
               ctl.first = atapio_pkg::make_error(atapio_pkg::ERR_BAD_COUNT);
            end else if (phase_ff != PH_IDLE) begin
               ctl.first = atapio_pkg::make_error(atapio_pkg::ERR_RUNNING);
            end else begin
               ctl.first = atapio_pkg::make_poll();
               lba_in    = in_ff.start_lba;
               wanted_in = in_ff.sector_total;
               done_in   = 9'd0;
               widx_in   = 8'd0;
               phase_in  = PH_START_POLL;
            end
         end
         atapio_pkg::CMD_RESET: begin
            ctl.kind  = atapio_pkg::BURST_RESET;
            phase_in  = PH_RESET_POLL;
            wanted_in = 9'd0;
            done_in   = 9'd0;
            widx_in   = 8'd0;
            lba_in    = 28'd0;
         end
         atapio_pkg::CMD_STATUS: begin
            ctl.kind = atapio_pkg::BURST_ONE;
            case (phase_ff)
               PH_START_POLL: begin
                  if (bad || in_ff.status_byte[atapio_pkg::ST_BSY]) begin
                     ctl.first = atapio_pkg::make_error(bad ? atapio_pkg::ERR_FAULT
                                                            : atapio_pkg::ERR_BUSY);
                     phase_in  = PH_IDLE;
                     wanted_in = 9'd0;
                     done_in   = 9'd0;
                     widx_in   = 8'd0;
                     lba_in    = 28'd0;
                  end else begin
                     ctl.kind = atapio_pkg::BURST_START;
                     phase_in = PH_WAIT_DRQ;
                  end
               end
               PH_WAIT_DRQ: begin
                  if (bad) begin
                     ctl.first = atapio_pkg::make_error(atapio_pkg::ERR_FAULT);
                     phase_in  = PH_IDLE;
                     wanted_in = 9'd0;
                     done_in   = 9'd0;
                     widx_in   = 8'd0;
                     lba_in    = 28'd0;
                  end else if (!in_ff.status_byte[atapio_pkg::ST_BSY] &&
                               in_ff.status_byte[atapio_pkg::ST_DRQ]) begin
                     ctl.kind = atapio_pkg::BURST_NONE;
                     phase_in = PH_DATA;
                     widx_in  = 8'd0;
                  end else begin
                     ctl.first = atapio_pkg::make_poll();
                  end
               end
               PH_RESET_POLL: begin
                  phase_in  = PH_IDLE;
                  wanted_in = 9'd0;
                  done_in   = 9'd0;
                  widx_in   = 8'd0;
                  lba_in    = 28'd0;
                  if (bad) begin
                     ctl.first = atapio_pkg::make_error(atapio_pkg::ERR_FAULT);
                  end else if (!in_ff.status_byte[atapio_pkg::ST_RDY]) begin
                     ctl.first = atapio_pkg::make_error(atapio_pkg::ERR_NOT_READY);
                  end else if (in_ff.status_byte[atapio_pkg::ST_IDX] ||
                               in_ff.status_byte[atapio_pkg::ST_CORR]) begin
                     ctl.first = atapio_pkg::make_error(atapio_pkg::ERR_CORRUPT);
                  end else begin
                     ctl.kind = atapio_pkg::BURST_NONE;
                  end
               end
               default: begin
                  ctl.first = atapio_pkg::make_error(atapio_pkg::ERR_UNEXPECTED);
               end
            endcase
         end
         default: begin
            ctl.kind = atapio_pkg::BURST_ONE;
            if (phase_ff == PH_DATA) begin
               ctl.first = data_rsp;
               if (widx_ff == 8'(atapio_pkg::WORDS_PER_SECTOR - 1)) begin
                  widx_in = 8'd0;
                  if (done_next >= wanted_ff) begin
                     ctl.first.request_done = 1'b1;
                     phase_in  = PH_IDLE;
                     wanted_in = 9'd0;
                     done_in   = 9'd0;
                     lba_in    = 28'd0;
                  end else begin
                     ctl.kind = atapio_pkg::BURST_DATA_POLL;
                     done_in  = done_next;
                     phase_in = PH_WAIT_DRQ;
                  end
               end else begin
                  widx_in = widx_ff + 8'd1;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         select_slave_ff <= 1'b0;
         in_valid_ff     <= 1'b0;
         phase_ff        <= PH_IDLE;
         wanted_ff       <= 9'd0;
         done_ff         <= 9'd0;
         widx_ff         <= 8'd0;
         lba_ff          <= 28'd0;
      end else begin
         if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
            select_slave_ff <= pwdata[0];
         end
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (load) begin
            phase_ff  <= phase_in;
            wanted_ff <= wanted_in;
            done_ff   <= done_in;
            widx_ff   <= widx_in;
            lba_ff    <= lba_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_data;
      end
   end

   atapio_burst u_burst (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .free      (free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
